// ===== hdl/srs_pkg.sv =====
// Shared types and constants for the strip restart stitcher.
// No dependencies; the front end, queue, back end, top level and checker import this package.
package srs_pkg;

  // Input word fields
  localparam logic [15:0] StartBit  = 16'h8000;
  localparam logic [15:0] ClearMask = 16'h7FFF;

  // Generated position count saturates here
  localparam logic [17:0] CountMax = 18'h3FFFF;

  // Command queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Result slots of one item, in emission order
  localparam int SlotNum = 7;

  // Result kinds
  typedef enum logic [1:0] {
    KindWord  = 2'd0,
    KindPos   = 2'd1,
    KindTotal = 2'd2
  } kind_e;

  // Classified item: everything the back needs to emit its results
  typedef struct packed {
    logic [15:0] word;       // input word, start bit cleared
    logic [15:0] idx;        // position of the item in the mesh
    logic [15:0] prior_end;  // last position of the previous run
    logic        stitch;     // emit degenerate stitch pair
    logic        open;       // emit run opening pair
    logic        own;        // emit own position
    logic        last;       // emit mesh total
    logic [17:0] total;      // total after this item's positions
  } cmd_t;

endpackage

// ===== hdl/srs_in_if.sv =====
// Input channel of the strip restart stitcher: valid/ready plus one strip word.
// Depends on nothing.
interface srs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] strip_word;
  logic        mesh_end;

  modport source (output valid, output strip_word, output mesh_end, input ready);
  modport sink   (input valid, input strip_word, input mesh_end, output ready);
endinterface

// ===== hdl/srs_out_if.sv =====
// Output channel of the strip restart stitcher: valid/ready plus one result.
// Depends on nothing.
interface srs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] word;
  logic [17:0] total;
  logic        final_res;

  modport source (output valid, output kind, output word, output total,
                  output final_res, input ready);
  modport sink   (input valid, input kind, input word, input total,
                  input final_res, output ready);
endinterface

// ===== hdl/srs_front.sv =====
// Front end: accepts strip words, tracks mesh state and classifies each beat
// into a command for the queue. Depends on srs_pkg and srs_in_if.
module srs_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  srs_in_if.sink       in_ch,
  input  logic         q_full_i,
  output logic         q_push_o,
  output srs_pkg::cmd_t q_cmd_o
);
  import srs_pkg::*;

  logic [15:0] position_q, position_d;
  logic        run_active_q, run_active_d;
  logic [15:0] prior_end_q, prior_end_d;
  logic        prior_valid_q, prior_valid_d;
  logic [17:0] count_q, count_d;

  logic        continues;
  logic        open_run;
  logic        stitch;
  logic [2:0]  n_pos;
  logic [18:0] count_sum;
  logic [17:0] count_new;

  // Accept whenever the queue has room
  assign in_ch.ready = !q_full_i;
  assign q_push_o    = in_ch.valid && !q_full_i;

  // Classify the beat
  always_comb begin
    continues = (position_q > 16'd1) && ((in_ch.strip_word & StartBit) == 16'd0);
    open_run  = continues && !run_active_q;
    stitch    = open_run && prior_valid_q;
    n_pos     = {stitch, 1'b0} + {open_run, 1'b0} + {2'b00, continues};
    count_sum = {1'b0, count_q} + {16'd0, n_pos};
    count_new = (count_sum > {1'b0, CountMax}) ? CountMax : count_sum[17:0];
  end

  always_comb begin
    q_cmd_o.word      = in_ch.strip_word & ClearMask;
    q_cmd_o.idx       = position_q;
    q_cmd_o.prior_end = prior_end_q;
    q_cmd_o.stitch    = stitch;
    q_cmd_o.open      = open_run;
    q_cmd_o.own       = continues;
    q_cmd_o.last      = in_ch.mesh_end;
    q_cmd_o.total     = count_new;
  end

  // Advance mesh state; clear it on the last word of a mesh
  always_comb begin
    position_d    = position_q;
    run_active_d  = run_active_q;
    prior_end_d   = prior_end_q;
    prior_valid_d = prior_valid_q;
    count_d       = count_q;
    if (q_push_o) begin
      if (in_ch.mesh_end) begin
        position_d    = 16'd0;
        run_active_d  = 1'b0;
        prior_end_d   = 16'd0;
        prior_valid_d = 1'b0;
        count_d       = 18'd0;
      end else begin
        position_d   = position_q + 16'd1;
        run_active_d = continues;
        count_d      = count_new;
        if (continues) begin
          prior_end_d   = position_q;
          prior_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= 16'd0;
      run_active_q  <= 1'b0;
      prior_end_q   <= 16'd0;
      prior_valid_q <= 1'b0;
      count_q       <= 18'd0;
    end else begin
      position_q    <= position_d;
      run_active_q  <= run_active_d;
      prior_end_q   <= prior_end_d;
      prior_valid_q <= prior_valid_d;
      count_q       <= count_d;
    end
  end

endmodule

// ===== hdl/srs_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on srs_pkg.
module srs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srs_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output srs_pkg::cmd_t head_cmd_o,
  output logic          full_o,
  output logic          empty_o
);
  import srs_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   fill_q, fill_d;

  assign full_o     = (fill_q == (QPtrW+1)'(QDepth));
  assign empty_o    = (fill_q == '0);
  assign head_cmd_o = mem_q[rd_ptr_q];

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// ===== hdl/srs_back.sv =====
// Back end: walks the result slots of the head command, one result beat per
// cycle unless stalled, into the output register. Depends on srs_pkg, srs_out_if.
module srs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srs_pkg::cmd_t head_cmd_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  srs_out_if.source     out_ch
);
  import srs_pkg::*;

  // Slot codes, in emission order
  localparam logic [2:0] SlotWord    = 3'd0;
  localparam logic [2:0] SlotStitchA = 3'd1;
  localparam logic [2:0] SlotStitchB = 3'd2;
  localparam logic [2:0] SlotOpenA   = 3'd3;
  localparam logic [2:0] SlotOpenB   = 3'd4;
  localparam logic [2:0] SlotOwn     = 3'd5;
  localparam logic [2:0] SlotTotal   = 3'd6;

  logic [2:0]         slot_q, slot_d;
  logic [SlotNum-1:0] mask;
  logic [2:0]         nxt;
  logic               found;
  logic               load;
  logic               fire;

  logic        valid_q, valid_d;
  kind_e       kind_q, kind_d;
  logic [15:0] word_q, word_d;
  logic [17:0] total_q, total_d;
  logic        final_q, final_d;

  assign out_ch.valid     = valid_q;
  assign out_ch.kind      = kind_q;
  assign out_ch.word      = word_q;
  assign out_ch.total     = total_q;
  assign out_ch.final_res = final_q;

  // Slots present in the head command
  assign mask = {head_cmd_i.last, head_cmd_i.own, head_cmd_i.open, head_cmd_i.open,
                 head_cmd_i.stitch, head_cmd_i.stitch, 1'b1};

  // Output register free or being drained
  assign load    = !valid_q || out_ch.ready;
  assign fire    = load && !q_empty_i;
  assign q_pop_o = fire && !found;

  // Find the next present slot above the current one
  always_comb begin
    nxt   = slot_q;
    found = 1'b0;
    for (int i = SlotNum - 1; i >= 0; i--) begin
      if (mask[i] && (3'(i) > slot_q)) begin
        nxt   = 3'(i);
        found = 1'b1;
      end
    end
  end

  // Build the result for the current slot
  always_comb begin
    slot_d  = slot_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    word_d  = word_q;
    total_d = total_q;
    final_d = final_q;
    if (fire) begin
      valid_d = 1'b1;
      final_d = !found;
      slot_d  = found ? nxt : SlotWord;
      kind_d  = KindPos;
      total_d = 18'd0;
      case (slot_q)
        SlotWord: begin
          kind_d = KindWord;
          word_d = head_cmd_i.word;
        end
        SlotStitchA: word_d = head_cmd_i.prior_end;
        SlotStitchB: word_d = head_cmd_i.idx - 16'd2;
        SlotOpenA:   word_d = head_cmd_i.idx - 16'd2;
        SlotOpenB:   word_d = head_cmd_i.idx - 16'd1;
        SlotOwn:     word_d = head_cmd_i.idx;
        SlotTotal: begin
          kind_d  = KindTotal;
          word_d  = 16'd0;
          total_d = head_cmd_i.total;
        end
        default: begin
          kind_d = KindWord;
          word_d = head_cmd_i.word;
        end
      endcase
    end else if (load) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SlotWord;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    word_q  <= word_d;
    total_q <= total_d;
    final_q <= final_d;
  end

endmodule

// ===== hdl/strip_restart_stitcher.sv =====
// Top level of the strip restart stitcher: front end, command queue, back end.
// Depends on srs_pkg, srs_in_if, srs_out_if, srs_front, srs_queue, srs_back.
//
// Usage:
//   in_ch carries one strip word per beat, with mesh_end on the last word of a
//   mesh. out_ch carries the results: the cleared word, then any stitch pair,
//   run opening pair and own position, then the mesh total on the last word;
//   final_res marks the last result beat of each input beat.
//   The first result of an input beat passes through the queue and then the
//   output register. Throughput: one result beat per cycle while out_ch.ready
//   is high, set by the single output register; an input beat yields 1 to 7
//   result beats, 4 commands may wait in the queue, so input is taken every
//   cycle while the queue has room, even when the output is stalled.
//   Stall: when out_ch.ready is low the output beat holds, the back end waits,
//   and in_ch.ready drops once the queue is full.
//   Reset: clears mesh state (position, run tracking, generated count), the
//   queue and the output valid; nothing is pending afterwards.
module strip_restart_stitcher (
  input  logic      clk_i,
  input  logic      rst_ni,
  srs_in_if.sink    in_ch,
  srs_out_if.source out_ch
);
  import srs_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  srs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .q_full_i (full),
    .q_push_o (push),
    .q_cmd_o  (push_cmd)
  );

  srs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .full_o     (full),
    .empty_o    (empty)
  );

  srs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_cmd_i (head_cmd),
    .q_empty_i  (empty),
    .q_pop_o    (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== hdl/srs_checker.sv =====
// Port-level checks on the strip restart stitcher output, bound to the top.
// Depends on srs_pkg.
module srs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [15:0] out_word_i,
  input logic [17:0] out_total_i,
  input logic        out_final_i
);
  import srs_pkg::*;

  // Stalled output beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable({out_kind_i, out_word_i, out_total_i, out_final_i}))
    else $error("output beat changed while stalled");

  // Mesh total is always the last result of its input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KindTotal) |-> out_final_i)
    else $error("mesh total not marked final");

  // Total field only carries a value on a total beat, and word is then zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_kind_i == KindWord) || (out_kind_i == KindPos)) |->
      (out_total_i == 18'd0))
    else $error("total set on a word or position beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KindTotal) |-> (out_word_i == 16'd0))
    else $error("word set on a total beat");

endmodule

bind strip_restart_stitcher srs_checker u_srs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_kind_i  (out_ch.kind),
  .out_word_i  (out_ch.word),
  .out_total_i (out_ch.total),
  .out_final_i (out_ch.final_res)
);
